[src/cws_pkg.sv]
// shared types, character codes and helper functions of the comment and whitespace stripper
package cws_pkg;

  // character codes
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // queue between the scanner and the output stage
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // scanner modes
  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_SLASH,
    MODE_STRING,
    MODE_CHAR,
    MODE_LINE,
    MODE_BLOCK
  } scan_mode_t;

  // results of one input byte, up to two of them
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic       two;   // both bytes carry results
    logic       v0;    // first result carries a byte, 0 for a bare end marker
    logic       done;  // final result closes the text
  } cws_entry_t;

  // identifier characters [A-Za-z0-9_$]
  function automatic logic is_ident(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER || c == CH_DOLLAR;
  endfunction

  // whitespace: tab through carriage return, and space
  function automatic logic is_ws(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

[src/cws_ifs.sv]
// valid/ready channel interfaces for source bytes and result bytes
interface cws_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface cws_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last_of_run;
  logic       text_done;

  modport source (output valid, output out_byte, output byte_valid,
                  output last_of_run, output text_done, input ready);
  modport sink (input valid, input out_byte, input byte_valid,
                input last_of_run, input text_done, output ready);
endinterface

[src/cws_front.sv]
// scanner: tracks comment and literal state and forms the results of each source byte
module cws_front (
  input  logic                clk,
  input  logic                rst_n,
  cws_in_if.sink              in_ch,
  input  logic                q_full,
  output logic                push,
  output cws_pkg::cws_entry_t push_entry
);

  cws_pkg::scan_mode_t mode_r, mode_nxt;
  logic       esc_r, esc_nxt;
  logic       sp_r, sp_nxt;
  logic [7:0] last_r, last_nxt;
  logic       star_r, star_nxt;

  logic [7:0] c;
  logic       eot;
  logic       xfer;
  logic       slash_release, run_normal, keep_c, lit, space_emit, flush;
  logic       c_ws, c_nl;
  logic [1:0] cnt;
  logic [7:0] b0, b1;
  logic       v0;

  assign c    = in_ch.in_byte;
  assign eot  = in_ch.end_of_text;
  assign xfer = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !q_full;

  // byte classification against the current mode
  assign c_ws = cws_pkg::is_ws(c);
  assign c_nl = (c == cws_pkg::CH_LF) || (c == cws_pkg::CH_CR);
  assign slash_release = (mode_r == cws_pkg::MODE_SLASH) &&
                         (c != cws_pkg::CH_SLASH) && (c != cws_pkg::CH_STAR);
  assign lit = (mode_r == cws_pkg::MODE_STRING) || (mode_r == cws_pkg::MODE_CHAR);
  assign run_normal = slash_release ||
                      !((mode_r == cws_pkg::MODE_SLASH) || lit ||
                        (mode_r == cws_pkg::MODE_LINE) || (mode_r == cws_pkg::MODE_BLOCK));
  assign keep_c = run_normal && !c_ws && (c != cws_pkg::CH_SLASH);
  assign space_emit = keep_c && !slash_release && sp_r &&
                      cws_pkg::is_ident(last_r) && cws_pkg::is_ident(c);
  assign flush = eot && run_normal && (c == cws_pkg::CH_SLASH);

  // next state
  always_comb begin
    mode_nxt = mode_r;
    esc_nxt  = esc_r;
    sp_nxt   = sp_r;
    last_nxt = last_r;
    star_nxt = star_r;
    unique case (mode_r)
      cws_pkg::MODE_SLASH: begin
        if (c == cws_pkg::CH_SLASH) begin
          mode_nxt = cws_pkg::MODE_LINE;
        end else if (c == cws_pkg::CH_STAR) begin
          mode_nxt = cws_pkg::MODE_BLOCK;
          star_nxt = 1'b0;
        end else begin
          mode_nxt = cws_pkg::MODE_NORMAL;
        end
      end
      cws_pkg::MODE_STRING, cws_pkg::MODE_CHAR: begin
        esc_nxt = !esc_r && (c == cws_pkg::CH_BSLASH);
        if (!esc_r && c != cws_pkg::CH_BSLASH &&
            c == ((mode_r == cws_pkg::MODE_STRING) ? cws_pkg::CH_DQUOTE
                                                   : cws_pkg::CH_SQUOTE)) begin
          mode_nxt = cws_pkg::MODE_NORMAL;
        end
      end
      cws_pkg::MODE_LINE: begin
        if (c_nl) begin
          mode_nxt = cws_pkg::MODE_NORMAL;
          sp_nxt   = 1'b1;
        end
      end
      cws_pkg::MODE_BLOCK: begin
        if (c == cws_pkg::CH_SLASH && star_r) begin
          mode_nxt = cws_pkg::MODE_NORMAL;
          sp_nxt   = 1'b1;
          star_nxt = 1'b0;
        end else begin
          star_nxt = (c == cws_pkg::CH_STAR);
        end
      end
      default: begin
        mode_nxt = cws_pkg::MODE_NORMAL;
      end
    endcase

    // plain text handling, also after a released slash
    if (run_normal) begin
      if (slash_release) begin
        sp_nxt   = 1'b0;
        last_nxt = cws_pkg::CH_SLASH;
      end
      if (c_ws) begin
        sp_nxt = 1'b1;
      end else if (c == cws_pkg::CH_SLASH) begin
        mode_nxt = cws_pkg::MODE_SLASH;
      end else begin
        sp_nxt   = 1'b0;
        last_nxt = c;
        if (c == cws_pkg::CH_DQUOTE) begin
          mode_nxt = cws_pkg::MODE_STRING;
          esc_nxt  = 1'b0;
        end else if (c == cws_pkg::CH_SQUOTE) begin
          mode_nxt = cws_pkg::MODE_CHAR;
          esc_nxt  = 1'b0;
        end
      end
    end
    if (lit) begin
      last_nxt = c;
    end

    // end of text returns everything to reset
    if (eot) begin
      mode_nxt = cws_pkg::MODE_NORMAL;
      esc_nxt  = 1'b0;
      sp_nxt   = 1'b0;
      last_nxt = cws_pkg::CH_NUL;
      star_nxt = 1'b0;
    end
  end

  // results of this byte, packed in order
  always_comb begin
    cnt = 2'd0;
    b0  = cws_pkg::CH_NUL;
    b1  = cws_pkg::CH_NUL;
    v0  = 1'b1;
    if (slash_release) begin
      b0  = cws_pkg::CH_SLASH;
      cnt = 2'd1;
    end
    if (space_emit) begin
      b0  = cws_pkg::CH_SPACE;
      cnt = 2'd1;
    end
    if (keep_c || lit) begin
      if (cnt == 2'd0) begin
        b0 = c;
      end else begin
        b1 = c;
      end
      cnt = cnt + 2'd1;
    end
    if (flush) begin
      if (cnt == 2'd0) begin
        b0 = cws_pkg::CH_SLASH;
      end else begin
        b1 = cws_pkg::CH_SLASH;
      end
      cnt = cnt + 2'd1;
    end
    if (eot && cnt == 2'd0) begin
      v0  = 1'b0;
      cnt = 2'd1;
    end
  end

  assign push            = xfer && (cnt != 2'd0);
  assign push_entry.b0   = b0;
  assign push_entry.b1   = b1;
  assign push_entry.two  = (cnt == 2'd2);
  assign push_entry.v0   = v0;
  assign push_entry.done = eot;

  // scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= cws_pkg::MODE_NORMAL;
      esc_r  <= 1'b0;
      sp_r   <= 1'b0;
      last_r <= cws_pkg::CH_NUL;
      star_r <= 1'b0;
    end else if (xfer) begin
      mode_r <= mode_nxt;
      esc_r  <= esc_nxt;
      sp_r   <= sp_nxt;
      last_r <= last_nxt;
      star_r <= star_nxt;
    end
  end

  // end of text leaves the scanner in its reset state
  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && eot |=> mode_r == cws_pkg::MODE_NORMAL && !sp_r && !esc_r &&
                    last_r == cws_pkg::CH_NUL)
    else $error("scanner state not cleared after end of text");

  // a bare end marker only closes a text and stands alone
  a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
    push && !push_entry.v0 |-> push_entry.done && !push_entry.two)
    else $error("bare end marker outside end of text");

endmodule

[src/cws_queue.sv]
// short queue of per-byte result entries between scanner and output stage
module cws_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cws_pkg::cws_entry_t push_entry,
  input  logic                pop,
  output cws_pkg::cws_entry_t head,
  output logic                empty,
  output logic                full
);

  cws_pkg::cws_entry_t entry_r [cws_pkg::QDEPTH];
  logic [cws_pkg::QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [cws_pkg::QAW:0]   count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == (cws_pkg::QAW+1)'(cws_pkg::QDEPTH));
  assign head  = entry_r[rd_ptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("transfer into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("pop from an empty queue");

endmodule

[src/cws_back.sv]
// output stage: issues queued results one transfer per cycle while the sink is ready, from a result register
module cws_back (
  input  logic                clk,
  input  logic                rst_n,
  input  cws_pkg::cws_entry_t head,
  input  logic                empty,
  output logic                pop,
  cws_out_if.source           out_ch
);

  logic       valid_r;
  logic       second_r, second_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       bvalid_r, bvalid_nxt;
  logic       last_r, last_nxt;
  logic       done_r, done_nxt;
  logic       load;
  logic       first_of_two;

  assign load         = !valid_r || out_ch.ready;
  assign first_of_two = head.two && !second_r;
  assign pop          = load && !empty && !first_of_two;

  // select the next result from the queue head
  always_comb begin
    second_nxt = second_r;
    byte_nxt   = head.b0;
    bvalid_nxt = head.v0;
    last_nxt   = 1'b1;
    done_nxt   = head.done;
    if (first_of_two) begin
      second_nxt = 1'b1;
      bvalid_nxt = 1'b1;
      last_nxt   = 1'b0;
      done_nxt   = 1'b0;
    end else begin
      second_nxt = 1'b0;
      if (second_r) begin
        byte_nxt   = head.b1;
        bvalid_nxt = 1'b1;
      end
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      second_r <= 1'b0;
    end else if (load) begin
      valid_r <= !empty;
      if (!empty) begin
        second_r <= second_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load && !empty) begin
      byte_r   <= byte_nxt;
      bvalid_r <= bvalid_nxt;
      last_r   <= last_nxt;
      done_r   <= done_nxt;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.out_byte    = byte_r;
  assign out_ch.byte_valid  = bvalid_r;
  assign out_ch.last_of_run = last_r;
  assign out_ch.text_done   = done_r;

  // the second half of a pair follows a shown first half that was not last
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> valid_r && !last_r && bvalid_r)
    else $error("second result without its first");

endmodule

[src/comment_whitespace_stripper.sv]
// Streaming comment and whitespace stripper: one source byte per transfer in, kept bytes out.
// Line and block comments are dropped, whitespace runs collapse to one space only between two
// identifier characters, and string and character literals pass unchanged. A slash is held
// until the next byte shows whether a comment opens. The input side takes one byte per cycle;
// each byte yields zero, one or two results, and the output register issues one result per
// cycle, so a byte that yields two results holds the output for both in turn. A four-entry
// queue between the scanner and the output register absorbs these bursts and output stalls;
// the input stalls only when that queue is full. Each result passes through the queue and then
// the output register. An input marked end_of_text closes the text with text_done on its last
// result (a bare end marker with byte_valid low if nothing else is left) and clears the state.
module comment_whitespace_stripper (
  input  logic      clk,
  input  logic      rst_n,
  cws_in_if.sink    in_ch,
  cws_out_if.source out_ch
);

  logic                push, pop, q_empty, q_full;
  cws_pkg::cws_entry_t push_entry, head;

  cws_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  cws_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  cws_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .empty  (q_empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
